@@ sv/multichannel_pcm_mixer_macros.svh @@
// ---------------------------------------------------------------------------
// multichannel_pcm_mixer assertion macros
// shared property forms for the mixer checker
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_PCM_MIXER_MACROS_SVH
`define MULTICHANNEL_PCM_MIXER_MACROS_SVH

// a stalled word keeps valid and payload
`define MPM_ASSERT_HOLD(label, vld, rdy, sig) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error("word changed while stalled");

// same-cycle implication
`define MPM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("implication failed");

// next-cycle implication
`define MPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("next-cycle implication failed");

`endif

@@ sv/mpm_pkg.sv @@
// ---------------------------------------------------------------------------
// mpm_pkg
// shared types and constants of the multichannel pcm mixer
// ---------------------------------------------------------------------------
package mpm_pkg;

    localparam int CHANNELS            = 4;
    localparam int SAMPLES_PER_CHANNEL = 1024;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = $clog2(SAMPLES_PER_CHANNEL);
    localparam int LEN_W     = POS_W + 1;
    localparam int MEM_DEPTH = CHANNELS * SAMPLES_PER_CHANNEL;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // input field widths
    localparam int ACTION_W = 3;
    localparam int CHAN_W   = 3;
    localparam int IDX_W    = 10;
    localparam int SAMPLE_W = 16;
    localparam int PLEN_W   = 11;
    localparam int VREQ_W   = 8;
    localparam int VOL_W    = 7;

    // s_tdata layout
    localparam int IN_CHAN_LSB = 0;
    localparam int IN_IDX_LSB  = IN_CHAN_LSB + CHAN_W;
    localparam int IN_SVAL_LSB = IN_IDX_LSB + IDX_W;
    localparam int IN_PLEN_LSB = IN_SVAL_LSB + SAMPLE_W;
    localparam int IN_LOOP_BIT = IN_PLEN_LSB + PLEN_W;
    localparam int IN_VREQ_LSB = IN_LOOP_BIT + 1;
    localparam int IN_USED_W   = IN_VREQ_LSB + VREQ_W;
    localparam int S_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // m_tdata layout
    localparam int OUT_LEFT_LSB   = 0;
    localparam int OUT_RIGHT_LSB  = SAMPLE_W;
    localparam int OUT_STATUS_BIT = 2 * SAMPLE_W;
    localparam int OUT_ACTIVE_BIT = OUT_STATUS_BIT + 1;
    localparam int OUT_USED_W     = OUT_ACTIVE_BIT + 1;
    localparam int M_TDATA_W      = ((OUT_USED_W + 7) / 8) * 8;

    // datapath arithmetic
    localparam int PROD_W      = SAMPLE_W + VOL_W + 1;
    localparam int MAG_W       = 22;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);
    localparam int QFULL_W     = MAG_W + RECIP_W;
    localparam int ACC_W       = SAMPLE_W + 2 + CH_W;

    localparam logic [VOL_W-1:0] VOL_FULL = VOL_W'(100);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 3'd0,
        ACT_PLAY   = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_VOLUME = 3'd3,
        ACT_MIX    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic            capture;
        logic            exec;
        logic            acc_clear;
        logic            issue;
        logic [CH_W-1:0] issue_ch;
        logic            finish;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic mix_go;
        logic busy;
    } stat_t;

endpackage

@@ sv/multichannel_pcm_mixer.sv @@
// ---------------------------------------------------------------------------
// multichannel_pcm_mixer
// multi-voice 16-bit pcm mixer with per-voice volume and saturation
// ---------------------------------------------------------------------------
// s_ channel carries command words: s_tuser is the action (load, play, stop,
// set volume, mix), s_tdata the operands. Every accepted word gives exactly
// one m_ word with the mixed sample (left and right equal), a status bit and
// the global active flag.
// Samples are loaded into an internal store of CHANNELS x SAMPLES_PER_CHANNEL
// entries before play; the user must load an entry before it is played, as
// the block itself does not enforce it. Load, play, stop, set volume and a
// mix while idle are executed directly; a mix while active issues one voice
// per cycle into the sample memory read port, then a two-multiplier scale
// pipeline (sample times volume, then the reciprocal of 100) and the
// accumulator, then saturation.
// One word is in work at a time; s_tready rises again once the result is in
// the output register, so a new word is taken while the result waits.
// If m_tready stays low, a finished result waits in the sequencer until the
// held word is taken. Reset stops all voices, clears volumes and the active
// flag and empties the output; the sample store is not cleared.
// ---------------------------------------------------------------------------
module multichannel_pcm_mixer
    import mpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // channel, sample_index, sample_value, play_length, loop_flag, volume_value
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [ACTION_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // left_sample, right_sample, status, any_active
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t  cmd;
    stat_t stat;

    mpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule

@@ sv/mpm_ctrl.sv @@
// ---------------------------------------------------------------------------
// mpm_ctrl
// sequencer: takes one word, runs the action or the per-voice mix, hands
// the result to the output register
// ---------------------------------------------------------------------------
module mpm_ctrl
    import mpm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t          state_reg, state_next;
    logic [CH_W-1:0] chan_cnt_reg, chan_cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chan_cnt_reg  <= chan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        chan_cnt_next  = chan_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.mix_go) begin
                    cmd.acc_clear = 1'b1;
                    chan_cnt_next = '0;
                    state_next    = ST_ISSUE;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_OUTPUT;
                end
            end
            ST_ISSUE: begin
                cmd.issue    = 1'b1;
                cmd.issue_ch = chan_cnt_reg;
                if (chan_cnt_reg == CH_W'(CHANNELS - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    chan_cnt_next = chan_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                // output register frees up when the held word is taken
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ sv/mpm_datapath.sv @@
// ---------------------------------------------------------------------------
// mpm_datapath
// voice registers, sample memory, scale pipeline, accumulator and
// output register
// ---------------------------------------------------------------------------
module mpm_datapath
    import mpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [ACTION_W-1:0]  s_tuser,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // captured word
    logic [ACTION_W-1:0]       item_action_reg;
    logic [CHAN_W-1:0]         item_ch_reg;
    logic [IDX_W-1:0]          item_idx_reg;
    logic signed [SAMPLE_W-1:0] item_sval_reg;
    logic [PLEN_W-1:0]         item_plen_reg;
    logic                      item_loop_reg;
    logic signed [VREQ_W-1:0]  item_vreq_reg;

    // voice state
    logic [LEN_W-1:0] voice_len_reg  [CHANNELS];
    logic [POS_W-1:0] voice_pos_reg  [CHANNELS];
    logic             voice_loop_reg [CHANNELS];
    logic [VOL_W-1:0] voice_vol_reg  [CHANNELS];
    logic             active_reg;

    // sample memory
    logic signed [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       mem_wr;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;

    // scale pipeline
    logic                     s1_occ_reg, s2_occ_reg, s3_occ_reg;
    logic                     s1_play_reg, s2_play_reg, s3_play_reg;
    logic [CH_W-1:0]          s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic [VOL_W-1:0]         s1_vol_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic                     s3_neg_reg;
    logic [SAMPLE_W-1:0]      s3_q_reg;
    logic signed [PROD_W-1:0] prod;
    logic [MAG_W-1:0]         mag;
    logic [QFULL_W-1:0]       qfull;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [LEN_W-1:0]         pos_inc;

    // results
    logic [SAMPLE_W-1:0]  res_mixed_reg;
    logic                 res_status_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 ch_ok;
    logic                 idx_ok;
    logic [CH_W-1:0]      ch_sel;
    logic [LEN_W-1:0]     play_len;
    logic [VOL_W-1:0]     vol_clamped;
    logic                 any_len;
    logic                 exec_status;
    logic [SAMPLE_W-1:0]  sat_sum;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_action_reg <= s_tuser;
            item_ch_reg     <= s_tdata[IN_CHAN_LSB +: CHAN_W];
            item_idx_reg    <= s_tdata[IN_IDX_LSB +: IDX_W];
            item_sval_reg   <= s_tdata[IN_SVAL_LSB +: SAMPLE_W];
            item_plen_reg   <= s_tdata[IN_PLEN_LSB +: PLEN_W];
            item_loop_reg   <= s_tdata[IN_LOOP_BIT];
            item_vreq_reg   <= s_tdata[IN_VREQ_LSB +: VREQ_W];
        end
    end

    assign ch_ok  = 32'(item_ch_reg) < CHANNELS;
    assign idx_ok = 32'(item_idx_reg) < SAMPLES_PER_CHANNEL;
    assign ch_sel = CH_W'(item_ch_reg);

    assign play_len = (32'(item_plen_reg) > SAMPLES_PER_CHANNEL) ?
                      LEN_W'(SAMPLES_PER_CHANNEL) : LEN_W'(item_plen_reg);

    always_comb begin
        if (item_vreq_reg < 0) begin
            vol_clamped = '0;
        end else if (item_vreq_reg > $signed(VREQ_W'(100))) begin
            vol_clamped = VOL_FULL;
        end else begin
            vol_clamped = VOL_W'(item_vreq_reg);
        end
    end

    always_comb begin
        exec_status = 1'b0;
        case (item_action_reg)
            ACT_LOAD:   exec_status = !(ch_ok && idx_ok);
            ACT_PLAY:   exec_status = !ch_ok || (item_plen_reg == '0);
            ACT_STOP:   exec_status = !ch_ok;
            ACT_VOLUME: exec_status = !ch_ok;
            ACT_MIX:    exec_status = 1'b0;
            default:    exec_status = 1'b1;
        endcase
    end

    assign mem_wr  = cmd.exec && (item_action_reg == ACT_LOAD) && ch_ok && idx_ok;
    assign wr_addr = ADDR_W'(ch_sel) * ADDR_W'(SAMPLES_PER_CHANNEL)
                   + ADDR_W'(POS_W'(item_idx_reg));
    assign rd_addr = ADDR_W'(cmd.issue_ch) * ADDR_W'(SAMPLES_PER_CHANNEL)
                   + ADDR_W'(voice_pos_reg[cmd.issue_ch]);

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            sample_mem[wr_addr] <= item_sval_reg;
        end
        if (cmd.issue) begin
            rd_data_reg <= sample_mem[rd_addr];
        end
    end

    // stage 1: sample times volume
    assign prod = rd_data_reg * $signed({1'b0, s1_vol_reg});

    // stage 2: magnitude over 100 by reciprocal, truncates toward zero
    assign mag   = s2_prod_reg[PROD_W-1] ? MAG_W'(-s2_prod_reg) : MAG_W'(s2_prod_reg);
    assign qfull = QFULL_W'(mag) * QFULL_W'(RECIP);

    // stage 3: signed add into the frame sum
    assign term    = s3_neg_reg ? -$signed(ACC_W'(s3_q_reg)) : $signed(ACC_W'(s3_q_reg));
    assign pos_inc = LEN_W'(voice_pos_reg[s3_ch_reg]) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_occ_reg <= 1'b0;
            s2_occ_reg <= 1'b0;
            s3_occ_reg <= 1'b0;
        end else begin
            s1_occ_reg <= cmd.issue;
            s2_occ_reg <= s1_occ_reg;
            s3_occ_reg <= s2_occ_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_play_reg <= voice_len_reg[cmd.issue_ch] != '0;
        s1_ch_reg   <= cmd.issue_ch;
        s1_vol_reg  <= voice_vol_reg[cmd.issue_ch];
        s2_play_reg <= s1_play_reg;
        s2_ch_reg   <= s1_ch_reg;
        s2_prod_reg <= prod;
        s3_play_reg <= s2_play_reg;
        s3_ch_reg   <= s2_ch_reg;
        s3_neg_reg  <= s2_prod_reg[PROD_W-1];
        s3_q_reg    <= qfull[RECIP_SHIFT +: SAMPLE_W];
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (s3_occ_reg && s3_play_reg) begin
            acc_reg <= acc_reg + term;
        end
    end

    always_comb begin
        any_len = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            any_len = any_len | (voice_len_reg[c] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                voice_len_reg[c]  <= '0;
                voice_pos_reg[c]  <= '0;
                voice_loop_reg[c] <= 1'b0;
                voice_vol_reg[c]  <= '0;
            end
            active_reg <= 1'b0;
        end else if (cmd.exec && ch_ok) begin
            case (item_action_reg)
                ACT_PLAY: begin
                    if (item_plen_reg != '0) begin
                        voice_len_reg[ch_sel]  <= play_len;
                        voice_pos_reg[ch_sel]  <= '0;
                        voice_loop_reg[ch_sel] <= item_loop_reg;
                        voice_vol_reg[ch_sel]  <= VOL_FULL;
                        active_reg             <= 1'b1;
                    end
                end
                ACT_STOP: begin
                    voice_len_reg[ch_sel]  <= '0;
                    voice_pos_reg[ch_sel]  <= '0;
                    voice_loop_reg[ch_sel] <= 1'b0;
                end
                ACT_VOLUME: begin
                    voice_vol_reg[ch_sel] <= vol_clamped;
                end
                default: begin
                end
            endcase
        end else if (s3_occ_reg && s3_play_reg) begin
            // advance, wrap or end the voice
            if (pos_inc >= voice_len_reg[s3_ch_reg]) begin
                voice_pos_reg[s3_ch_reg] <= '0;
                if (!voice_loop_reg[s3_ch_reg]) begin
                    voice_len_reg[s3_ch_reg] <= '0;
                end
            end else begin
                voice_pos_reg[s3_ch_reg] <= POS_W'(pos_inc);
            end
        end else if (cmd.finish && !any_len) begin
            active_reg <= 1'b0;
        end
    end

    always_comb begin
        if (acc_reg > SAT_HI) begin
            sat_sum = SAMPLE_W'(SAT_HI);
        end else if (acc_reg < SAT_LO) begin
            sat_sum = SAMPLE_W'(SAT_LO);
        end else begin
            sat_sum = SAMPLE_W'(acc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_mixed_reg  <= '0;
            res_status_reg <= exec_status;
        end else if (cmd.finish) begin
            res_mixed_reg  <= sat_sum;
            res_status_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= M_TDATA_W'({active_reg, res_status_reg,
                                        res_mixed_reg, res_mixed_reg});
        end
    end

    assign stat.mix_go = (item_action_reg == ACT_MIX) && active_reg;
    assign stat.busy   = s1_occ_reg || s2_occ_reg || s3_occ_reg;
    assign m_tdata     = out_data_reg;

endmodule

@@ sv/mpm_checker.sv @@
// ---------------------------------------------------------------------------
// mpm_checker
// port-level checks of the mixer, bound to the top level
// ---------------------------------------------------------------------------
`include "multichannel_pcm_mixer_macros.svh"

module mpm_checker
    import mpm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [ACTION_W-1:0]  s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [SAMPLE_W-1:0] out_left;
    logic [SAMPLE_W-1:0] out_right;
    logic                out_status;

    assign out_left   = m_tdata[OUT_LEFT_LSB +: SAMPLE_W];
    assign out_right  = m_tdata[OUT_RIGHT_LSB +: SAMPLE_W];
    assign out_status = m_tdata[OUT_STATUS_BIT];

    `MPM_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata)

    `MPM_ASSERT_IMPL(a_stereo_equal, m_tvalid, out_left == out_right)

    `MPM_ASSERT_IMPL(a_reject_silent, m_tvalid && out_status, out_left == '0)

    `MPM_ASSERT_NEXT(a_one_word_in_work, s_tvalid && s_tready, !s_tready)

endmodule

bind multichannel_pcm_mixer mpm_checker u_mpm_checker (.*);

@@ dv/tb_multichannel_pcm_mixer.sv @@
// ---------------------------------------------------------------------------
// tb_multichannel_pcm_mixer
// self-checking regression for the multi-voice pcm mixer
// ---------------------------------------------------------------------------
// Command words go in on the s_ side and one result word per command comes
// back on the m_ side. A behavioral copy of the mixer state (sample store,
// voice lengths, positions, loop flags, volumes, active flag) predicts every
// result word at the moment its command is accepted. Result words are checked
// field by field in order. Plays only ever cover sample entries that were
// loaded before, so the mixer never reads an unwritten store entry.
// ---------------------------------------------------------------------------
module tb_multichannel_pcm_mixer;
    import mpm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_PLEN    = (1 << PLEN_W) - 1;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic [CHAN_W-1:0]          chan;
        logic [IDX_W-1:0]           idx;
        logic signed [SAMPLE_W-1:0] sval;
        logic [PLEN_W-1:0]          plen;
        logic                       loop_en;
        logic signed [VREQ_W-1:0]   vreq;
    } mixer_cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       status;
        logic                       active;
    } mix_frame_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACTION_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // mixer state as the block should hold it
    logic signed [SAMPLE_W-1:0] pcm_store [MEM_DEPTH];
    bit                         store_written [MEM_DEPTH];
    logic [LEN_W-1:0]           voice_len [CHANNELS];
    logic [POS_W-1:0]           voice_pos [CHANNELS];
    logic                       voice_loop_en [CHANNELS];
    logic [VOL_W-1:0]           voice_vol [CHANNELS];
    logic                       mixer_on;

    mix_frame_t pending_frames[$];
    mix_frame_t want_frame;
    mix_frame_t seen_frame;

    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    multichannel_pcm_mixer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multichannel_pcm_mixer regression: fail");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic mix_frame_t predict_frame(mixer_cmd_t cmd);
        mix_frame_t f;
        bit         ch_ok;
        bit         any_playing;
        int         c;
        int         p;
        int         sum;
        int         v;
        f     = '0;
        ch_ok = cmd.chan < CHANNELS;
        case (cmd.action)
            ACT_LOAD: begin
                if (ch_ok && cmd.idx < SAMPLES_PER_CHANNEL) begin
                    p = int'(cmd.chan) * SAMPLES_PER_CHANNEL + int'(cmd.idx);
                    pcm_store[p]     = cmd.sval;
                    store_written[p] = 1'b1;
                end else begin
                    f.status = 1'b1;
                end
            end
            ACT_PLAY: begin
                if (!ch_ok || cmd.plen == 0) begin
                    f.status = 1'b1;
                end else begin
                    voice_len[cmd.chan]     = (cmd.plen > SAMPLES_PER_CHANNEL) ?
                                              LEN_W'(SAMPLES_PER_CHANNEL) : cmd.plen;
                    voice_pos[cmd.chan]     = '0;
                    voice_loop_en[cmd.chan] = cmd.loop_en;
                    voice_vol[cmd.chan]     = VOL_FULL;
                    mixer_on                = 1'b1;
                end
            end
            ACT_STOP: begin
                if (ch_ok) begin
                    voice_len[cmd.chan]     = '0;
                    voice_pos[cmd.chan]     = '0;
                    voice_loop_en[cmd.chan] = 1'b0;
                end else begin
                    f.status = 1'b1;
                end
            end
            ACT_VOLUME: begin
                if (ch_ok) begin
                    v = cmd.vreq;
                    if (v < 0)
                        v = 0;
                    if (v > 100)
                        v = 100;
                    voice_vol[cmd.chan] = v[VOL_W-1:0];
                end else begin
                    f.status = 1'b1;
                end
            end
            ACT_MIX: begin
                if (mixer_on) begin
                    sum = 0;
                    for (c = 0; c < CHANNELS; c++) begin
                        if (voice_len[c] != 0) begin
                            p = voice_pos[c];
                            if (p >= SAMPLES_PER_CHANNEL)
                                p = 0;
                            // int division truncates toward zero
                            sum += (int'(pcm_store[c * SAMPLES_PER_CHANNEL + p]) *
                                    int'(voice_vol[c])) / 100;
                            p++;
                            if (p >= voice_len[c]) begin
                                p = 0;
                                if (!voice_loop_en[c])
                                    voice_len[c] = '0;
                            end
                            voice_pos[c] = POS_W'(p);
                        end
                    end
                    if (sum > 32767)
                        sum = 32767;
                    if (sum < -32768)
                        sum = -32768;
                    f.left = sum[SAMPLE_W-1:0];
                    any_playing = 1'b0;
                    for (c = 0; c < CHANNELS; c++)
                        if (voice_len[c] != 0)
                            any_playing = 1'b1;
                    if (!any_playing)
                        mixer_on = 1'b0;
                end
            end
            default: begin
                f.status = 1'b1;
            end
        endcase
        f.right  = f.left;
        f.active = mixer_on;
        return f;
    endfunction

    // number of entries loaded from the start of a voice region
    function automatic int loaded_prefix(int c);
        int n;
        n = 0;
        while (n < SAMPLES_PER_CHANNEL && store_written[c * SAMPLES_PER_CHANNEL + n])
            n++;
        return n;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return SAMPLE_W'(32767);
            1: return SAMPLE_W'(-32768);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // command word with all unused operands random
    function automatic mixer_cmd_t make_cmd(logic [ACTION_W-1:0] action,
                                            logic [CHAN_W-1:0] chan);
        mixer_cmd_t cmd;
        cmd.action  = action;
        cmd.chan    = chan;
        cmd.idx     = IDX_W'($urandom);
        cmd.sval    = SAMPLE_W'($urandom);
        cmd.plen    = PLEN_W'($urandom);
        cmd.loop_en = 1'($urandom);
        cmd.vreq    = VREQ_W'($urandom);
        return cmd;
    endfunction

    function automatic logic [CHAN_W-1:0] bad_chan();
        return CHAN_W'($urandom_range(CHANNELS, (1 << CHAN_W) - 1));
    endfunction

    // entered and left at a falling edge; valid stays high into the next word
    task automatic send_word(mixer_cmd_t cmd);
        logic [S_TDATA_W-1:0] data;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        data = '0;
        data[IN_CHAN_LSB +: CHAN_W]   = cmd.chan;
        data[IN_IDX_LSB  +: IDX_W]    = cmd.idx;
        data[IN_SVAL_LSB +: SAMPLE_W] = cmd.sval;
        data[IN_PLEN_LSB +: PLEN_W]   = cmd.plen;
        data[IN_LOOP_BIT]             = cmd.loop_en;
        data[IN_VREQ_LSB +: VREQ_W]   = cmd.vreq;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.action;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_frames.push_back(predict_frame(cmd));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_frames.size() != 0)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_frame.left   = m_tdata[OUT_LEFT_LSB +: SAMPLE_W];
            seen_frame.right  = m_tdata[OUT_RIGHT_LSB +: SAMPLE_W];
            seen_frame.status = m_tdata[OUT_STATUS_BIT];
            seen_frame.active = m_tdata[OUT_ACTIVE_BIT];
            if (pending_frames.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end else begin
                want_frame = pending_frames.pop_front();
                if (seen_frame.left !== want_frame.left) begin
                    $error("left_sample: expected %0d actual %0d",
                           want_frame.left, seen_frame.left);
                    fail_count++;
                end
                if (seen_frame.right !== want_frame.right) begin
                    $error("right_sample: expected %0d actual %0d",
                           want_frame.right, seen_frame.right);
                    fail_count++;
                end
                if (seen_frame.status !== want_frame.status) begin
                    $error("status: expected %0d actual %0d",
                           want_frame.status, seen_frame.status);
                    fail_count++;
                end
                if (seen_frame.active !== want_frame.active) begin
                    $error("any_active: expected %0d actual %0d",
                           want_frame.active, seen_frame.active);
                    fail_count++;
                end
            end
        end
    end

    // mix while idle, unused actions, bad channels, zero length
    task automatic test_idle_and_errors();
        mixer_cmd_t cmd;
        int         a;
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        for (a = int'(ACT_MIX) + 1; a < (1 << ACTION_W); a++)
            send_word(make_cmd(ACTION_W'(a), CHAN_W'($urandom)));
        send_word(make_cmd(ACT_LOAD, bad_chan()));
        cmd = make_cmd(ACT_PLAY, bad_chan());
        cmd.plen = PLEN_W'($urandom_range(1, MAX_PLEN));
        send_word(cmd);
        cmd = make_cmd(ACT_PLAY, CHAN_W'($urandom_range(CHANNELS - 1)));
        cmd.plen = '0;
        send_word(cmd);
        send_word(make_cmd(ACT_STOP, bad_chan()));
        send_word(make_cmd(ACT_VOLUME, bad_chan()));
    endtask

    // full-scale sums, clamped volumes, truncation, end and wrap of a voice
    task automatic test_saturation_and_volume();
        mixer_cmd_t cmd;
        int         c;
        for (c = 1; c <= 2; c++) begin
            cmd = make_cmd(ACT_LOAD, CHAN_W'(c));
            cmd.idx  = 0;
            cmd.sval = SAMPLE_W'(32767);
            send_word(cmd);
            cmd = make_cmd(ACT_LOAD, CHAN_W'(c));
            cmd.idx  = 1;
            cmd.sval = SAMPLE_W'(-32768);
            send_word(cmd);
            cmd = make_cmd(ACT_PLAY, CHAN_W'(c));
            cmd.plen    = 2;
            cmd.loop_en = (c == 2);
            send_word(cmd);
        end
        // positive then negative saturation, voice 1 ends, voice 2 wraps
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        cmd = make_cmd(ACT_VOLUME, 2);
        cmd.vreq = -8'sd128;
        send_word(cmd);
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        cmd.vreq = 8'sd127;
        send_word(cmd);
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        cmd.vreq = 8'sd33;
        send_word(cmd);
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        // stop keeps the active flag until the next mix
        send_word(make_cmd(ACT_STOP, 2));
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
    endtask

    // whole region of voice 0 loaded, length beyond the region
    task automatic test_full_region();
        mixer_cmd_t cmd;
        int         i;
        for (i = 0; i < SAMPLES_PER_CHANNEL; i++) begin
            cmd = make_cmd(ACT_LOAD, 0);
            cmd.idx  = IDX_W'(i);
            cmd.sval = pick_sample();
            send_word(cmd);
        end
        cmd = make_cmd(ACT_PLAY, 0);
        cmd.plen    = PLEN_W'($urandom_range(SAMPLES_PER_CHANNEL + 1, MAX_PLEN));
        cmd.loop_en = 1'b1;
        send_word(cmd);
        cmd = make_cmd(ACT_VOLUME, 0);
        cmd.vreq = VREQ_W'($urandom_range(1, 127));
        send_word(cmd);
        repeat (8)
            send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
        send_word(make_cmd(ACT_STOP, 0));
        send_word(make_cmd(ACT_MIX, CHAN_W'($urandom)));
    endtask

    // mostly well-formed load/play/mix traffic with some noise
    task automatic test_random_traffic(int words);
        mixer_cmd_t cmd;
        int         ch;
        int         pick;
        int         n;
        int         top;
        repeat (words) begin
            ch   = $urandom_range(CHANNELS - 1);
            pick = $urandom_range(99);
            cmd  = make_cmd(ACT_MIX, CHAN_W'($urandom));
            if (pick < 12) begin
                // grow the loaded part of a voice region
                cmd = make_cmd(ACT_LOAD, CHAN_W'(ch));
                n   = loaded_prefix(ch);
                cmd.idx  = (n < SAMPLES_PER_CHANNEL) ? IDX_W'(n) : IDX_W'($urandom);
                cmd.sval = pick_sample();
            end else if (pick < 18) begin
                cmd = make_cmd(ACT_LOAD, CHAN_W'($urandom));
                cmd.sval = pick_sample();
            end else if (pick < 28) begin
                cmd = make_cmd(ACT_PLAY, CHAN_W'(ch));
                n   = loaded_prefix(ch);
                top = (n == SAMPLES_PER_CHANNEL) ? MAX_PLEN : n;
                if ($urandom_range(3) != 0 && top > 48)
                    top = 48;
                cmd.plen = (top == 0) ? '0 : PLEN_W'($urandom_range(1, top));
            end else if (pick < 33) begin
                cmd = make_cmd(ACT_STOP, CHAN_W'(ch));
            end else if (pick < 40) begin
                cmd = make_cmd(ACT_VOLUME, CHAN_W'(ch));
            end else if (pick >= 85) begin
                cmd = make_cmd(ACTION_W'($urandom), CHAN_W'($urandom));
                // a noise play on a real voice must not reach unloaded entries
                if (cmd.action == ACT_PLAY && cmd.chan < CHANNELS)
                    cmd.plen = '0;
                if (cmd.action == ACT_LOAD)
                    cmd.sval = pick_sample();
            end
            send_word(cmd);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        mixer_on      = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 31;
        recv_idle_pct = 84;
        for (int c = 0; c < CHANNELS; c++) begin
            voice_len[c]     = '0;
            voice_pos[c]     = '0;
            voice_loop_en[c] = 1'b0;
            voice_vol[c]     = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_and_errors();
        wait_drained();
        test_saturation_and_volume();
        test_random_traffic(60);
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 31;
        test_full_region();
        test_random_traffic(60);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(60);
        wait_drained();

        // let any stray word show up
        repeat (24) @(posedge aclk);
        if (fail_count == 0) begin
            $display("multichannel_pcm_mixer regression: pass");
        end else begin
            $display("multichannel_pcm_mixer regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mpm_pkg.sv
sv/mpm_ctrl.sv
sv/mpm_datapath.sv
sv/multichannel_pcm_mixer.sv
sv/mpm_checker.sv
dv/tb_multichannel_pcm_mixer.sv
